// ===== hw/rtl/dfs_pkg.sv =====
// Shared types and constants for the delimiter field splitter.
`timescale 1ns / 1ps

package dfs_pkg;

    // Per-cycle control handed to every cell of the history chain
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t CFG_DELIMITER_BYTES  = 2'd0;
    localparam cfg_index_t CFG_DELIMITER_LENGTH = 2'd1;
    localparam cfg_index_t CFG_MAX_FIELDS       = 2'd2;

    localparam logic [31:0] DELIMITER_BYTES_RST  = 32'd2573;
    localparam logic [2:0]  DELIMITER_LENGTH_RST = 3'd2;
    localparam logic [4:0]  MAX_FIELDS_RST       = 5'd16;

endpackage

// ===== hw/rtl/delimiter_field_splitter.sv =====
// Top level of the delimiter field splitter: history chain, field tracking and result register.
//
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      s_data_byte, s_end_of_slice
//  m_        out        m_valid / m_ready      m_field_index, m_field_offset,
//                                              m_field_length, m_final_field
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte per cycle while s_ready is high; a result appears in the output register
// the cycle after the byte that closes its field. The delimiter compare over the
// held bytes and the position add and compare are combinational.
// Reset (aresetn low, synchronous) restores the register defaults and clears
// the slice state. s_ready drops only while a result waits and m_ready is low.
// cfg_ready is always high.
`timescale 1ns / 1ps

module delimiter_field_splitter #(
    parameter int MAX_DELIM       = 4,
    parameter int MAX_FIELD_COUNT = 16,
    parameter int POSITION_BITS   = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    input  logic                 s_end_of_slice,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [3:0]           m_field_index,
    output logic [15:0]          m_field_offset,
    output logic [15:0]          m_field_length,
    output logic                 m_final_field,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  dfs_pkg::cfg_index_t  cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int DL_W  = $clog2(MAX_DELIM + 1);
    localparam int MF_W  = $clog2(MAX_FIELD_COUNT + 1);
    localparam int POS_W = POSITION_BITS;
    localparam int SUM_W = POS_W + 1;
    localparam logic [POS_W-1:0] POS_LIMIT = {POS_W{1'b1}};

    // configuration
    logic [31:0] delimiter_bytes_reg;
    logic [2:0]  delimiter_length_reg;
    logic [4:0]  max_fields_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delimiter_bytes_reg  <= dfs_pkg::DELIMITER_BYTES_RST;
            delimiter_length_reg <= dfs_pkg::DELIMITER_LENGTH_RST;
            max_fields_reg       <= dfs_pkg::MAX_FIELDS_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                dfs_pkg::CFG_DELIMITER_BYTES:  delimiter_bytes_reg  <= cfg_data;
                dfs_pkg::CFG_DELIMITER_LENGTH: delimiter_length_reg <= cfg_data[2:0];
                dfs_pkg::CFG_MAX_FIELDS:       max_fields_reg       <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    logic [DL_W-1:0] dlen;
    logic [MF_W-1:0] mf;

    always_comb begin
        if (32'(delimiter_length_reg) > MAX_DELIM) begin
            dlen = DL_W'(MAX_DELIM);
        end else if (delimiter_length_reg == 3'd0) begin
            dlen = DL_W'(1);
        end else begin
            dlen = DL_W'(delimiter_length_reg);
        end
        if (32'(max_fields_reg) > MAX_FIELD_COUNT) begin
            mf = MF_W'(MAX_FIELD_COUNT);
        end else if (max_fields_reg == 5'd0) begin
            mf = MF_W'(1);
        end else begin
            mf = MF_W'(max_fields_reg);
        end
    end

    // delimiter byte expected at each look-back distance
    logic [7:0]           delim_byte [MAX_DELIM];
    logic [7:0]           want       [MAX_DELIM];
    logic [MAX_DELIM-1:0] active;

    always_comb begin
        for (int i = 0; i < MAX_DELIM; i++) begin
            delim_byte[i] = (i < 4) ? delimiter_bytes_reg[8*(i%4) +: 8] : 8'd0;
        end
        for (int b = 0; b < MAX_DELIM; b++) begin
            want[b]   = 8'd0;
            active[b] = (b < 32'(dlen));
            for (int i = 0; i < MAX_DELIM; i++) begin
                if (i + b == 32'(dlen) - 1) begin
                    want[b] = delim_byte[i];
                end
            end
        end
    end

    // history chain: chain[0] is the current byte, chain[k+1] the byte k+1 back
    logic                 s_fire;
    dfs_pkg::cell_ctrl_t  cell_ctrl;
    logic [7:0]           chain [MAX_DELIM];
    logic [MAX_DELIM-1:0] hit;

    assign s_fire          = s_valid && s_ready;
    assign cell_ctrl.shift = s_fire;
    assign cell_ctrl.clear = s_end_of_slice;
    assign chain[0]        = s_data_byte;
    assign hit[0]          = (s_data_byte == want[0]);

    for (genvar k = 0; k < MAX_DELIM - 1; k++) begin : g_cell
        dfs_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (cell_ctrl),
            .d_in    (chain[k]),
            .want    (want[k+1]),
            .active  (active[k+1]),
            .q_out   (chain[k+1]),
            .hit     (hit[k+1])
        );
    end

    // field tracking
    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [MF_W-1:0]  fe_reg,    fe_next;

    logic [SUM_W-1:0] pos_inc;
    logic [POS_W-1:0] pos_sat;
    logic [SUM_W-1:0] close_len;
    logic [SUM_W-1:0] rest_len;
    logic             room;
    logic             match;
    logic             res_valid;
    logic [POS_W-1:0] res_len;
    logic             res_final;

    always_comb begin
        pos_inc   = SUM_W'(pos_reg) + SUM_W'(1);
        pos_sat   = (pos_reg == POS_LIMIT) ? POS_LIMIT : pos_reg + POS_W'(1);
        room      = ({1'b0, fe_reg} + (MF_W + 1)'(1)) < {1'b0, mf};
        match     = room && (pos_inc >= SUM_W'(start_reg) + SUM_W'(dlen)) && (&hit);
        close_len = pos_inc - SUM_W'(dlen) - SUM_W'(start_reg);
        rest_len  = (pos_inc >= SUM_W'(start_reg)) ? pos_inc - SUM_W'(start_reg) : '0;

        res_valid = match || s_end_of_slice;
        res_final = s_end_of_slice;
        if (match) begin
            res_len = close_len[POS_W] ? POS_LIMIT : close_len[POS_W-1:0];
        end else begin
            res_len = rest_len[POS_W] ? POS_LIMIT : rest_len[POS_W-1:0];
        end

        pos_next   = pos_reg;
        start_next = start_reg;
        fe_next    = fe_reg;
        if (s_fire) begin
            if (s_end_of_slice) begin
                pos_next   = '0;
                start_next = '0;
                fe_next    = '0;
            end else begin
                pos_next = pos_sat;
                if (match) begin
                    start_next = pos_sat;
                    fe_next    = fe_reg + MF_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            start_reg <= '0;
            fe_reg    <= '0;
        end else begin
            pos_reg   <= pos_next;
            start_reg <= start_next;
            fe_reg    <= fe_next;
        end
    end

    // result register
    logic                m_valid_reg;
    logic [3:0]          index_reg;
    logic [15:0]         offset_reg;
    logic [15:0]         length_reg;
    logic                final_reg;
    logic [MF_W+3:0]     index_ext;
    logic [POS_W+15:0]   offset_ext;
    logic [POS_W+15:0]   length_ext;

    assign s_ready    = !m_valid_reg || m_ready;
    assign index_ext  = {4'd0, fe_reg};
    assign offset_ext = {16'd0, start_reg};
    assign length_ext = {16'd0, res_len};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire && res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && res_valid) begin
            index_reg  <= index_ext[3:0];
            offset_reg <= offset_ext[15:0];
            length_reg <= length_ext[15:0];
            final_reg  <= res_final;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_field_index  = index_reg;
    assign m_field_offset = offset_reg;
    assign m_field_length = length_reg;
    assign m_final_field  = final_reg;

    // checks
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_end_of_slice |=> pos_reg == '0 && start_reg == '0 && fe_reg == '0)
        else $error("slice state not cleared after end of slice");

    a_end_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_end_of_slice |=> m_valid_reg && final_reg)
        else $error("end of slice produced no final item");

    a_start_behind_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg <= pos_reg)
        else $error("field start ahead of byte position");

    a_field_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(fe_reg) < MAX_FIELD_COUNT)
        else $error("field count beyond bound");

endmodule

// ===== hw/rtl/dfs_cell.sv =====
// One history cell: holds a past byte, passes it on and compares it with its delimiter byte.
`timescale 1ns / 1ps

module dfs_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  dfs_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]          d_in,
    input  logic [7:0]          want,
    input  logic                active,
    output logic [7:0]          q_out,
    output logic                hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb begin
        byte_next = byte_reg;
        if (ctrl.shift) begin
            byte_next = ctrl.clear ? 8'd0 : d_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'd0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign q_out = byte_reg;
    assign hit   = !active || (byte_reg == want);

endmodule

// ===== sim/delimiter_field_splitter_tb.sv =====
// Self-checking testbench for the delimiter field splitter, with a field predictor and random stalls.
`timescale 1ns / 1ps

module delimiter_field_splitter_tb;

    typedef struct packed {
        logic [3:0]  field_index;
        logic [15:0] field_offset;
        logic [15:0] field_length;
        logic        final_field;
    } field_t;

    localparam int unsigned POS_MAX = 65535;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [7:0]          s_data_byte    = 8'h00;
    logic                s_end_of_slice = 1'b0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [3:0]          m_field_index;
    logic [15:0]         m_field_offset;
    logic [15:0]         m_field_length;
    logic                m_final_field;
    logic                cfg_valid      = 1'b0;
    logic                cfg_ready;
    dfs_pkg::cfg_index_t cfg_index      = dfs_pkg::CFG_DELIMITER_BYTES;
    logic [31:0]         cfg_data       = 32'h0;

    // Predictor copy of the registers and the slice state
    logic [31:0] delim_cfg      = dfs_pkg::DELIMITER_BYTES_RST;
    logic [2:0]  delim_len_cfg  = dfs_pkg::DELIMITER_LENGTH_RST;
    logic [4:0]  max_fields_cfg = dfs_pkg::MAX_FIELDS_RST;
    logic [7:0]  held_bytes [0:2];
    int unsigned slice_pos;
    int unsigned field_start;
    int unsigned fields_done;

    field_t      pending_fields [$];
    field_t      oldest_field;
    int          errors         = 0;
    int          items_sent     = 0;
    int          fields_checked = 0;
    int          config_phases  = 0;
    bit          idle_on        = 1'b1;
    int          hold_cycles    = 0;
    int          ready_gap      = 0;

    delimiter_field_splitter dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_end_of_slice (s_end_of_slice),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_field_index  (m_field_index),
        .m_field_offset (m_field_offset),
        .m_field_length (m_field_length),
        .m_final_field  (m_final_field),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int unsigned sat_pos(int unsigned v);
        return (v > POS_MAX) ? POS_MAX : v;
    endfunction

    function automatic int unsigned delim_len_eff();
        if (delim_len_cfg == 3'd0) return 1;
        if (delim_len_cfg > 3'd4) return 4;
        return 32'(delim_len_cfg);
    endfunction

    function automatic void clear_slice_state();
        held_bytes[0] = 8'h00;
        held_bytes[1] = 8'h00;
        held_bytes[2] = 8'h00;
        slice_pos     = 0;
        field_start   = 0;
        fields_done   = 0;
    endfunction

    function automatic void predict_fields(logic [7:0] b, logic eos);
        int unsigned dl;
        int unsigned mf;
        int unsigned back;
        int unsigned len;
        int unsigned i;
        logic [7:0]  want;
        logic [7:0]  have;
        bit          hit;
        field_t      f;
        dl  = delim_len_eff();
        mf  = (max_fields_cfg == 5'd0) ? 1 :
              ((max_fields_cfg > 5'd16) ? 16 : 32'(max_fields_cfg));
        hit = 1'b0;
        if (fields_done < mf - 1 && slice_pos + 1 >= field_start + dl) begin
            hit = 1'b1;
            for (i = 0; i < dl; i++) begin
                back = dl - 1 - i;
                want = delim_cfg[8*i +: 8];
                have = (back == 0) ? b : held_bytes[back-1];
                if (have != want) hit = 1'b0;
            end
        end
        if (hit) begin
            len            = sat_pos(slice_pos + 1 - dl - field_start);
            f.field_index  = fields_done[3:0];
            f.field_offset = field_start[15:0];
            f.field_length = len[15:0];
            f.final_field  = eos;
            pending_fields.push_back(f);
            fields_done++;
            field_start = sat_pos(slice_pos + 1);
        end else if (eos) begin
            len            = (slice_pos + 1 >= field_start) ? sat_pos(slice_pos + 1 - field_start) : 0;
            f.field_index  = fields_done[3:0];
            f.field_offset = field_start[15:0];
            f.field_length = len[15:0];
            f.final_field  = 1'b1;
            pending_fields.push_back(f);
        end
        if (eos) begin
            clear_slice_state();
        end else begin
            held_bytes[2] = held_bytes[1];
            held_bytes[1] = held_bytes[0];
            held_bytes[0] = b;
            slice_pos     = sat_pos(slice_pos + 1);
        end
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Result side: random stalls, plus a long hold-off when asked
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else if (ready_gap > 0) begin
            m_ready <= 1'b0;
            ready_gap = ready_gap - 1;
        end else begin
            m_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) ready_gap = $urandom_range(1, 7);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_fields.size() == 0) begin
                errors++;
                $display("%0t: unexpected field, expected none, actual index %0d offset %0d length %0d",
                         $time, m_field_index, m_field_offset, m_field_length);
            end else begin
                oldest_field = pending_fields.pop_front();
                fields_checked++;
                compare_field("field_index", oldest_field.field_index, m_field_index);
                compare_field("field_offset", oldest_field.field_offset, m_field_offset);
                compare_field("field_length", oldest_field.field_length, m_field_length);
                compare_field("final_field", oldest_field.final_field, m_final_field);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 7) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_data_byte    <= b;
        s_end_of_slice <= eos;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        predict_fields(b, eos);
    endtask

    task automatic send_bytes(input logic [7:0] seq [$]);
        int i;
        for (i = 0; i < seq.size(); i++) send_byte(seq[i], i == seq.size() - 1);
    endtask

    task automatic cfg_write(input dfs_pkg::cfg_index_t idx, input logic [31:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            dfs_pkg::CFG_DELIMITER_BYTES:  delim_cfg      = data;
            dfs_pkg::CFG_DELIMITER_LENGTH: delim_len_cfg  = data[2:0];
            dfs_pkg::CFG_MAX_FIELDS:       max_fields_cfg = data[4:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] d, input logic [2:0] l, input logic [4:0] m);
        cfg_write(dfs_pkg::CFG_DELIMITER_BYTES, d);
        cfg_write(dfs_pkg::CFG_DELIMITER_LENGTH, {29'd0, l});
        cfg_write(dfs_pkg::CFG_MAX_FIELDS, {27'd0, m});
        config_phases++;
    endtask

    task automatic wait_idle();
        int n;
        @(negedge aclk);
        s_valid <= 1'b0;
        n = 0;
        while (pending_fields.size() > 0 && n < 5000) begin
            @(posedge aclk);
            n++;
        end
        if (pending_fields.size() > 0) begin
            errors++;
            $display("%0t: %0d expected fields missing, actual none", $time, pending_fields.size());
            pending_fields.delete();
        end
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 255));
            1, 2:    return 8'(delim_cfg >> (8 * $urandom_range(0, 3)));
            default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
    endfunction

    // Fields of random content joined by the delimiter; some slices are noise or cut delimiters
    task automatic send_slice();
        logic [7:0] seq [$];
        int n;
        int f;
        int k;
        int dl;
        bit broken;
        bit end_on_delim;
        dl           = delim_len_eff();
        broken       = ($urandom_range(0, 4) == 0);
        end_on_delim = ($urandom_range(0, 3) == 0);
        n            = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        if (broken && $urandom_range(0, 1)) begin
            repeat ($urandom_range(1, 12)) seq.push_back(pick_byte());
        end else begin
            for (f = 0; f < n; f++) begin
                repeat ($urandom_range(0, 5)) seq.push_back(pick_byte());
                if (f < n - 1 || end_on_delim) begin
                    k = (broken && $urandom_range(0, 2) == 0) ? $urandom_range(0, dl - 1) : dl;
                    for (int j = 0; j < k; j++) seq.push_back(delim_cfg[8*j +: 8]);
                end
            end
        end
        if (seq.size() == 0) seq.push_back(pick_byte());
        send_bytes(seq);
    endtask

    task automatic test_default_crlf();
        send_bytes('{8'h41, 8'h0D, 8'h0A, 8'h42});
        send_bytes('{8'h0D, 8'h0A});
        send_bytes('{8'h00, 8'h0D});
        wait_idle();
    endtask

    task automatic test_non_overlapping();
        set_config(32'h0000_6161, 3'd2, 5'd16);
        send_bytes('{8'h61, 8'h61, 8'h61, 8'h61, 8'h62});
        wait_idle();
    endtask

    task automatic test_field_limit();
        set_config(32'h0000_002C, 3'd1, 5'd0);
        send_bytes('{8'h2C, 8'h2C, 8'h00});
        wait_idle();
    endtask

    task automatic test_length_clamp();
        set_config(32'hFFFF_FFFF, 3'd0, 5'd16);
        send_bytes('{8'hFF, 8'h00, 8'hFF});
        wait_idle();
        set_config(32'h00FF_00FF, 3'd7, 5'd31);
        send_bytes('{8'h01, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h02});
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        logic [7:0] seq [$];
        set_config(32'h0000_002C, 3'd1, 5'd16);
        repeat (20) begin
            seq.push_back(8'($urandom_range(8'h30, 8'h7A)));
            seq.push_back(8'h2C);
        end
        hold_cycles = 80;
        send_bytes(seq);
        wait_idle();
    endtask

    task automatic test_random_slices(input int count);
        logic [31:0] d;
        logic [7:0]  rb;
        logic [2:0]  l;
        logic [4:0]  m;
        int          first;
        first = items_sent;
        while (items_sent - first < count) begin
            rb = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 2))
                0:       d = $urandom;
                1:       d = {4{rb}};
                default: d = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            endcase
            l = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
            case ($urandom_range(0, 3))
                0:       m = 5'($urandom_range(0, 31));
                1:       m = 5'($urandom_range(1, 4));
                2:       m = 5'd16;
                default: m = $urandom_range(0, 1) ? 5'd31 : 5'd1;
            endcase
            set_config(d, l, m);
            repeat (12) send_slice();
            wait_idle();
        end
    endtask

    initial begin
        clear_slice_state();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_default_crlf();
        test_non_overlapping();
        test_field_limit();
        test_length_clamp();
        test_output_backpressure();
        test_random_slices(500);
        idle_on = 1'b0;
        test_random_slices(150);
        $display("Sent %0d bytes over %0d register settings and checked %0d fields,",
                 items_sent, config_phases, fields_checked);
        $display("including stalls, field limits and clamped lengths.");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
